@@ rtl/core/lfpd_pkg.sv @@
// Shared types and constants for the line follower PD steering block.
// Self-contained; imported by line_follower_pd_steering.
`timescale 1ns / 1ps

package lfpd_pkg;

	localparam int SAMPLE_W = 12;
	localparam int TIME_W   = 32;
	localparam int GAIN_W   = 16;
	localparam int IVAL_W   = 16;
	localparam int ERR_W    = 4;
	localparam int DIFF_W   = 5;
	localparam int CORR_W   = 21;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Input item kind, carried on s_tuser.
	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_START  = 2'd1,
		OP_STOP   = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_INTERVAL  = 2'd1,
		REG_PROP_GAIN = 2'd2,
		REG_DERIV_GAIN = 2'd3
	} reg_idx_t;

	localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd2048;
	localparam logic [IVAL_W-1:0]   INTERVAL_RST  = 16'd10;

	// Line error codes.
	localparam logic signed [ERR_W-1:0] ERR_ZERO    = 4'sd0;
	localparam logic signed [ERR_W-1:0] ERR_POS_ONE = 4'sd1;
	localparam logic signed [ERR_W-1:0] ERR_NEG_ONE = -4'sd1;
	localparam logic signed [ERR_W-1:0] ERR_POS_THR = 4'sd3;
	localparam logic signed [ERR_W-1:0] ERR_NEG_THR = -4'sd3;
	localparam logic signed [ERR_W-1:0] ERR_POS_LOST = 4'sd5;
	localparam logic signed [ERR_W-1:0] ERR_NEG_LOST = -4'sd5;

endpackage

@@ rtl/core/line_follower_pd_steering.sv @@
// Top level of the three-sensor line follower with PD steering correction.
// Depends on lfpd_pkg for widths, operation codes and register indexes.
`timescale 1ns / 1ps

// Usage:
// Items enter on the s_* stream: s_tuser carries the operation (sample,
// start or stop) and s_tdata the three reflectance samples and the
// millisecond timestamp. Each item gives exactly one result on the m_*
// stream: the steering correction, the line-seen flag and the armed flag,
// all taken after that item's update.
// An item passes first through the input register and then through the
// result register, whose valid flag drives m_tvalid, before its result
// can be transferred on the m_* stream to the receiver. The thresholding,
// the error mapping and both gain products fit between those two registers,
// so the block takes one item per clock cycle when the receiver keeps up.
// When the receiver stalls, the result register holds its data and the
// input register still takes one more item; after that s_tready drops
// until the result is taken.
// Reset clears the armed flag, the timestamp, the errors, the correction
// and all valid flags, and restores the register defaults (threshold 2048,
// interval 10 ms, both gains 0). The configuration port writes one
// register per cycle with cfg_we high; write it only while no item is in
// flight.
module line_follower_pd_steering
	import lfpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Slave stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [71:0]           s_tdata,  // left[11:0], mid[23:12], right[35:24], now_ms[67:36]
	input  logic [1:0]            s_tuser,  // operation[1:0]
	// Master stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,  // steer_correction[20:0], line_seen[21], following[22]
	// Configuration.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// Configuration registers.
	logic [SAMPLE_W-1:0] threshold_q;
	logic [IVAL_W-1:0]   interval_q;
	logic [GAIN_W-1:0]   prop_gain_q;
	logic [GAIN_W-1:0]   deriv_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= THRESHOLD_RST;
			interval_q   <= INTERVAL_RST;
			prop_gain_q  <= '0;
			deriv_gain_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_THRESHOLD:  threshold_q  <= cfg_wdata[SAMPLE_W-1:0];
				REG_INTERVAL:   interval_q   <= cfg_wdata[IVAL_W-1:0];
				REG_PROP_GAIN:  prop_gain_q  <= cfg_wdata[GAIN_W-1:0];
				REG_DERIV_GAIN: deriv_gain_q <= cfg_wdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register stage.
	logic                valid_s1;
	op_t                 op_s1;
	logic [SAMPLE_W-1:0] left_s1, mid_s1, right_s1;
	logic [TIME_W-1:0]   now_s1;

	// Result register.
	logic                out_valid_q;
	logic [CORR_W-1:0]   out_corr_q;
	logic                out_seen_q;
	logic                out_follow_q;

	logic adv;
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= op_t'(s_tuser);
			left_s1  <= s_tdata[11:0];
			mid_s1   <= s_tdata[23:12];
			right_s1 <= s_tdata[35:24];
			now_s1   <= s_tdata[67:36];
		end
	end

	// Follower state.
	logic                      armed_q;
	logic [TIME_W-1:0]         last_upd_q;
	logic signed [ERR_W-1:0]   prev_err_q;
	logic signed [ERR_W-1:0]   older_err_q;
	logic signed [CORR_W-1:0]  corr_q;
	logic                      seen_q;

	// Update decision and error mapping.
	logic                     item_go;
	logic                     due;
	logic                     upd_go;
	logic [TIME_W-1:0]        elapsed;
	logic [2:0]               pat;
	logic signed [ERR_W-1:0]  err_new;
	logic signed [ERR_W-1:0]  older_new;
	logic signed [DIFF_W-1:0] diff;
	logic signed [CORR_W-1:0] p_term, d_term, corr_new;

	assign item_go = valid_s1 && adv;
	assign elapsed = now_s1 - last_upd_q;
	assign due     = elapsed >= {{(TIME_W-IVAL_W){1'b0}}, interval_q};
	assign upd_go  = item_go && (op_s1 == OP_SAMPLE) && armed_q && due;

	assign pat = {left_s1 > threshold_q, mid_s1 > threshold_q, right_s1 > threshold_q};

	always_comb begin
		case (pat)
			3'b010:  err_new = ERR_ZERO;
			3'b110:  err_new = ERR_NEG_ONE;
			3'b011:  err_new = ERR_POS_ONE;
			3'b100:  err_new = ERR_NEG_THR;
			3'b001:  err_new = ERR_POS_THR;
			3'b000:  err_new = (prev_err_q > ERR_ZERO) ? ERR_POS_LOST : ERR_NEG_LOST;
			default: err_new = prev_err_q;  // all three or the outer two: keep the error
		endcase
	end

	// A changed error pushes the previous one into the older slot.
	assign older_new = (err_new != prev_err_q) ? prev_err_q : older_err_q;
	assign diff      = DIFF_W'(err_new) - DIFF_W'(older_new);

	assign p_term   = $signed({{(CORR_W-GAIN_W){1'b0}}, prop_gain_q})
	                * $signed({{(CORR_W-ERR_W){err_new[ERR_W-1]}}, err_new});
	assign d_term   = $signed({{(CORR_W-GAIN_W){1'b0}}, deriv_gain_q})
	                * $signed({{(CORR_W-DIFF_W){diff[DIFF_W-1]}}, diff});
	assign corr_new = p_term + d_term;

	// Next-state values, also loaded into the result register.
	logic                     armed_d;
	logic signed [CORR_W-1:0] corr_d;
	logic                     seen_d;

	always_comb begin
		armed_d = armed_q;
		corr_d  = corr_q;
		seen_d  = seen_q;
		if (item_go) begin
			case (op_s1)
				OP_START: armed_d = 1'b1;
				OP_STOP: begin
					armed_d = 1'b0;
					corr_d  = '0;
				end
				OP_SAMPLE: begin
					if (upd_go) begin
						corr_d = corr_new;
						seen_d = |pat;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			last_upd_q  <= '0;
			prev_err_q  <= ERR_ZERO;
			older_err_q <= ERR_ZERO;
			corr_q      <= '0;
			seen_q      <= 1'b0;
		end else begin
			armed_q <= armed_d;
			corr_q  <= corr_d;
			seen_q  <= seen_d;
			if (item_go && op_s1 == OP_START) begin
				last_upd_q <= now_s1;
			end
			if (upd_go) begin
				last_upd_q  <= now_s1;
				prev_err_q  <= err_new;
				older_err_q <= older_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_go) begin
			out_corr_q   <= corr_d;
			out_seen_q   <= seen_d;
			out_follow_q <= armed_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_follow_q, out_seen_q, out_corr_q};

	// While disarmed the correction stays cleared.
	a_disarmed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> corr_q == '0)
		else $error("correction nonzero while disarmed");

	// Only the mapped error codes can be stored.
	a_err_codes: assert property (@(posedge clk) disable iff (!arst_n)
		prev_err_q == ERR_ZERO || prev_err_q == ERR_POS_ONE || prev_err_q == ERR_NEG_ONE ||
		prev_err_q == ERR_POS_THR || prev_err_q == ERR_NEG_THR ||
		prev_err_q == ERR_POS_LOST || prev_err_q == ERR_NEG_LOST)
		else $error("previous error outside the mapped codes");

	// The two tracked errors differ once any change has happened.
	a_err_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		prev_err_q != older_err_q || prev_err_q == ERR_ZERO)
		else $error("older error equals previous error");

	// An item leaving the input stage always lands in the result register.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		item_go |=> out_valid_q)
		else $error("item lost between stages");

	// A stop item reports disarmed with a cleared correction.
	a_stop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(item_go && op_s1 == OP_STOP) |=> (!out_follow_q && out_corr_q == '0))
		else $error("stop result not cleared");

endmodule
